>>> rtl/rptw_pkg.sv
// ----------------------------------------------------------------------------
// Radix page-table walker package
// Shared sizes, beat types and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rptw_pkg;

  localparam int TABLE_ENTRIES = 512;
  localparam int LEVELS        = 5;
  localparam int TABLE_POOL    = 64;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int TBL_W  = $clog2(TABLE_POOL);
  localparam int ADDR_W = TBL_W + IDX_W;
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int CNT_W  = $clog2(TABLE_POOL + 1);
  localparam int PN_W   = 45;
  localparam int VAL_W  = 32;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [PN_W-1:0]  page_number;
    logic [VAL_W-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic             out_of_tables;
  } rsp_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic rd;
    logic dir_adv;
    logic alloc;
    logic leaf_old;
    logic leaf_new;
    logic fail;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic at_leaf;
    logic last_dir;
    logic entry_zero;
    logic pool_short;
    logic rsp_free;
  } sts_t;

endpackage

>>> rtl/rptw_datapath.sv
// ----------------------------------------------------------------------------
// Radix page-table walker datapath
// Holds the table store, the walk registers, the free-table counter and the
// response register, and carries out the commands of the controller.
// ----------------------------------------------------------------------------
module rptw_datapath import rptw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output sts_t sts,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  logic [VAL_W-1:0] mem [TABLE_POOL*TABLE_ENTRIES];
  logic [VAL_W-1:0] rdata;
  logic             op;
  logic [PN_W-1:0]  pn;
  logic [VAL_W-1:0] val;
  logic [LVL_W-1:0] lvl;
  logic [TBL_W-1:0] tbl;
  logic [CNT_W-1:0] nft;
  logic [ADDR_W-1:0] clr_addr;
  logic [IDX_W-1:0] idx_cur;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] waddr;
  logic [VAL_W-1:0] wdata;
  logic             we;
  logic [CNT_W-1:0] needed;
  logic [CNT_W-1:0] avail;
  logic             rsp_free;
  logic             leaf_done;

  always_comb begin
    idx_cur = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (lvl == LVL_W'(l)) begin
        idx_cur = pn[(LEVELS-1-l)*IDX_W +: IDX_W];
      end
    end
  end

  assign addr      = {tbl, idx_cur};
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign leaf_done = cmd.leaf_old || cmd.leaf_new;
  assign needed    = CNT_W'(LEVELS - 1) - CNT_W'(lvl);
  assign avail     = (nft < CNT_W'(TABLE_POOL)) ? CNT_W'(TABLE_POOL) - nft : '0;

  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = val;
    if (cmd.clear_step) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if (cmd.alloc) begin
      we    = 1'b1;
      wdata = VAL_W'(nft);
    end else if (leaf_done && op == OP_WRITE) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= req_data.operation;
      pn  <= req_data.page_number;
      val <= req_data.entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl      <= '0;
      tbl      <= '0;
      nft      <= CNT_W'(1);
      clr_addr <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.load) begin
        lvl <= '0;
        tbl <= '0;
      end else if (cmd.dir_adv) begin
        lvl <= lvl + 1'b1;
        tbl <= rdata[TBL_W-1:0];
      end else if (cmd.alloc) begin
        lvl <= lvl + 1'b1;
        tbl <= nft[TBL_W-1:0];
        nft <= nft + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (leaf_done || cmd.fail) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fail) begin
      rsp_data.read_value    <= '0;
      rsp_data.out_of_tables <= 1'b1;
    end else if (leaf_done) begin
      rsp_data.out_of_tables <= 1'b0;
      if (op == OP_WRITE) begin
        rsp_data.read_value <= val;
      end else if (cmd.leaf_old) begin
        rsp_data.read_value <= rdata;
      end else begin
        rsp_data.read_value <= '0;
      end
    end
  end

  assign sts.clear_last = (clr_addr == '1);
  assign sts.at_leaf    = (lvl == LVL_W'(LEVELS - 1));
  assign sts.last_dir   = (lvl == LVL_W'(LEVELS - 2));
  assign sts.entry_zero = (rdata == '0);
  assign sts.pool_short = (needed > avail);
  assign sts.rsp_free   = rsp_free;

  // The free-table counter never passes the size of the pool.
  assert property (@(posedge clk) disable iff (rst) nft <= CNT_W'(TABLE_POOL))
    else $error("free-table counter beyond pool");

  // A table is only allocated while one is left.
  assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |-> nft < CNT_W'(TABLE_POOL))
    else $error("allocation from an empty pool");

  // Each allocation moves the counter on by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |=> nft == $past(nft) + 1'b1)
    else $error("free-table counter did not advance");

  // A response is only produced into a free response register.
  assert property (@(posedge clk) disable iff (rst)
    (leaf_done || cmd.fail) |-> rsp_free)
    else $error("response register overwritten");

endmodule

>>> rtl/rptw_ctrl.sv
// ----------------------------------------------------------------------------
// Radix page-table walker controller
// Sequences the clearing pass after reset, the directory reads, the table
// allocations and the leaf access of each request.
// ----------------------------------------------------------------------------
module rptw_ctrl import rptw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_ALLOC = 3'd4;
  localparam logic [2:0] S_NEW   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        priority if (sts.at_leaf) begin
          if (sts.rsp_free) begin
            cmd.leaf_old = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (!sts.entry_zero) begin
          cmd.dir_adv = 1'b1;
          state_next  = S_READ;
        end else if (sts.pool_short) begin
          if (sts.rsp_free) begin
            cmd.fail   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        if (sts.last_dir) begin
          state_next = S_NEW;
        end
      end
      S_NEW: begin
        if (sts.rsp_free) begin
          cmd.leaf_new = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign req_stall = (state != S_IDLE);

  // A request beat is always followed by the first directory read.
  assert property (@(posedge clk) disable iff (rst) cmd.load |=> state == S_READ)
    else $error("walk did not start after a request beat");

  // At most one step of a walk is commanded in a cycle.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.rd, cmd.dir_adv, cmd.alloc, cmd.leaf_old,
              cmd.leaf_new, cmd.fail, cmd.clear_step}))
    else $error("conflicting datapath commands");

  // A walk only finishes when the response register can take the beat.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.leaf_old || cmd.leaf_new || cmd.fail) |-> sts.rsp_free)
    else $error("walk finished into a full response register");

endmodule

>>> rtl/radix_page_table_walker.sv
// ----------------------------------------------------------------------------
// Radix page-table walker
// Reads or writes a leaf page-table entry through a five-level radix tree,
// allocating missing tables from a fixed pool.
// ----------------------------------------------------------------------------
// Usage: a request beat on req carries an operation, a page number and an
// entry value. Each request gives exactly one response beat on rsp with the
// leaf entry after the access, or with out_of_tables set when the pool cannot
// supply the tables the walk needs; the leaf is then left untouched.
// All tables live in one single-port memory, so the walk is sequential: each
// directory level that exists costs a read and a check, each missing level an
// allocation. The next request is taken the cycle after the response is
// loaded. After reset the block clears the whole table store, one word a
// cycle; req_stall stays high during that pass.
// The response register holds one beat; while rsp_stall holds it full, a
// walk that is ready to finish waits in place and req_stall stays high.
// ----------------------------------------------------------------------------
module radix_page_table_walker import rptw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  cmd_t cmd;
  sts_t sts;

  rptw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  rptw_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule
